// ===== hw/rtl/rlms_pkg.sv =====
// ----------------------------------------------------------------------------
// rlms_pkg: shared types and codes of the LED matrix row scanner
// Item command codes, color plane codes and the structs passed between
// the frame store, the scan core and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package rlms_pkg;

    typedef enum logic [0:0] {
        CMD_TICK  = 1'b0,
        CMD_WRITE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        PLANE_RED   = 2'd0,
        PLANE_GREEN = 2'd1,
        PLANE_BLUE  = 2'd2,
        PLANE_NONE  = 2'd3
    } t_plane;

    localparam int unsigned CFG_LIGHTS = 0;
    localparam int unsigned CFG_DWELL  = 1;

    localparam logic [15:0] DWELL_RESET = 16'd1000;

    // Bytes of one row as the scan core sees them.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_row_colors;

    // One write into the frame store.
    typedef struct packed {
        logic       en;
        logic [2:0] row;
        t_plane     plane;
        logic [7:0] data;
    } t_store_wr;

    // One result item.
    typedef struct packed {
        logic       serial_bit;
        logic       shift_strobe;
        logic [7:0] row_drive;
        logic       frame_end;
    } t_result;

endpackage

`default_nettype wire

// ===== hw/rtl/rlms_frame_store.sv =====
// ----------------------------------------------------------------------------
// rlms_frame_store: red, green and blue bytes of every row
// Three byte banks of ROWS entries, cleared at reset, written one byte at a
// time and read for one row at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module rlms_frame_store
    import rlms_pkg::*;
#(
    parameter int ROWS = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_store_wr                i_wr,
    input  wire logic [$clog2(ROWS)-1:0]  i_rd_row,
    output t_row_colors                   o_colors
);

    localparam int RowW = $clog2(ROWS);

    logic [7:0] r_red   [ROWS];
    logic [7:0] r_green [ROWS];
    logic [7:0] r_blue  [ROWS];

    logic            wr_ok;
    logic [RowW-1:0] wr_row;

    // Writes to the unused plane code or to a row beyond the matrix are dropped.
    assign wr_ok  = i_wr.en && (i_wr.plane != PLANE_NONE) && (int'(i_wr.row) < ROWS);
    assign wr_row = RowW'(i_wr.row);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ROWS; i++) begin
                r_red[i]   <= '0;
                r_green[i] <= '0;
                r_blue[i]  <= '0;
            end
        end else if (wr_ok) begin
            unique case (i_wr.plane)
                PLANE_RED:   r_red[wr_row]   <= i_wr.data;
                PLANE_GREEN: r_green[wr_row] <= i_wr.data;
                PLANE_BLUE:  r_blue[wr_row]  <= i_wr.data;
                default: ;
            endcase
        end
    end

    assign o_colors.red   = r_red[i_rd_row];
    assign o_colors.green = r_green[i_rd_row];
    assign o_colors.blue  = r_blue[i_rd_row];

endmodule

`default_nettype wire

// ===== hw/rtl/rlms_scan_core.sv =====
// ----------------------------------------------------------------------------
// rlms_scan_core: row, bit and dwell sequencing of the scan
// Holds the scan position, forms the result of the current tick and steps
// the position on every accepted tick item.
// ----------------------------------------------------------------------------
`default_nettype none

module rlms_scan_core
    import rlms_pkg::*;
#(
    parameter int ROWS = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_fire,
    input  wire t_cmd                     i_cmd,
    input  wire t_row_colors              i_colors,
    input  wire logic [7:0]               i_lights,
    input  wire logic [15:0]              i_dwell,
    output logic [$clog2(ROWS)-1:0]       o_row,
    output t_result                       o_result
);

    localparam int RowW = $clog2(ROWS);
    localparam logic [RowW-1:0] LastRow = RowW'(ROWS - 1);

    logic [RowW-1:0] r_row,   n_row;
    logic [4:0]      r_bit,   n_bit;
    logic            r_dwell, n_dwell;
    logic [15:0]     r_count, n_count;

    logic [31:0] word;
    logic [15:0] limit;
    logic [16:0] count_next;
    logic [3:0]  row_ext;
    logic        dwell_done;

    assign word       = {i_lights, i_colors.red, i_colors.green, i_colors.blue};
    assign limit      = (i_dwell == 16'd0) ? 16'd1 : i_dwell;
    assign count_next = {1'b0, r_count} + 17'd1;
    assign dwell_done = count_next >= {1'b0, limit};
    assign row_ext    = 4'(r_row);

    always_comb begin
        o_result.serial_bit   = 1'b0;
        o_result.shift_strobe = 1'b0;
        o_result.frame_end    = 1'b0;
        o_result.row_drive    = 8'hFF;
        // Rows past the eighth have no enable pin and leave all bits high.
        if (r_dwell && !row_ext[3]) begin
            o_result.row_drive[row_ext[2:0]] = 1'b0;
        end
        if (i_cmd == CMD_TICK) begin
            if (!r_dwell) begin
                o_result.serial_bit   = word[~r_bit];
                o_result.shift_strobe = 1'b1;
            end else begin
                o_result.frame_end = dwell_done && (r_row == LastRow);
            end
        end
    end

    always_comb begin
        n_row   = r_row;
        n_bit   = r_bit;
        n_dwell = r_dwell;
        n_count = r_count;
        if (i_fire && (i_cmd == CMD_TICK)) begin
            if (!r_dwell) begin
                n_bit = r_bit + 5'd1;
                if (r_bit == 5'd31) begin
                    n_dwell = 1'b1;
                    n_count = '0;
                end
            end else if (dwell_done) begin
                n_row   = (r_row == LastRow) ? '0 : r_row + RowW'(1);
                n_dwell = 1'b0;
                n_count = '0;
                n_bit   = '0;
            end else begin
                n_count = count_next[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_bit   <= '0;
            r_dwell <= 1'b0;
            r_count <= '0;
        end else begin
            r_row   <= n_row;
            r_bit   <= n_bit;
            r_dwell <= n_dwell;
            r_count <= n_count;
        end
    end

    assign o_row = r_row;

endmodule

`default_nettype wire

// ===== hw/rtl/rgb_led_matrix_row_scanner.sv =====
// ----------------------------------------------------------------------------
// rgb_led_matrix_row_scanner: multiplexed row scan of an RGB LED matrix
// Frame store of red, green and blue bytes per row, scanned row by row.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries items. tuser = 0 is a tick that advances the
//   scan by one shift clock or one dwell count; tuser = 1 writes the byte in
//   tdata into the frame store at the given row and plane.
//   Every item produces exactly one result transfer on the output stream:
//   the serial bit (valid when tuser is 1), the active-low row enables and
//   tlast on the tick that releases the last row of a frame.
//   Output valid rises in the cycle after the input transfer. One item is
//   taken in every cycle while the receiver keeps up; the only limit is the
//   single output register, which is refilled in the same cycle it is read.
//   When the receiver stalls, the output register holds its result and
//   s_axis_tready drops until it is taken.
//   Reset clears the frame store, the scan position and the output valid flag;
//   lights_byte resets to 0 and dwell_ticks to 1000. The user must write
//   registers through the cfg port while the stream is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_led_matrix_row_scanner
    import rlms_pkg::*;
#(
    parameter int ROWS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // row_sel[2:0], plane[4:3], data[12:5]
    input  wire logic [0:0]  s_axis_tuser,  // command[0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,  // serial_bit[0], row_drive[8:1]
    output logic [0:0]       m_axis_tuser,  // shift_strobe[0]
    output logic             m_axis_tlast,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_addr,
    input  wire logic [15:0] i_cfg_wdata
);

    localparam int RowW = $clog2(ROWS);

    logic [7:0]  r_lights_byte;
    logic [15:0] r_dwell_ticks;
    logic        r_out_valid;
    t_result     r_out;

    logic            fire;
    t_cmd            cmd;
    t_store_wr       store_wr;
    t_row_colors     colors;
    t_result         result;
    logic [RowW-1:0] scan_row;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign fire          = s_axis_tvalid && s_axis_tready;
    assign cmd           = t_cmd'(s_axis_tuser[0]);

    assign store_wr.en    = fire && (cmd == CMD_WRITE);
    assign store_wr.row   = s_axis_tdata[2:0];
    assign store_wr.plane = t_plane'(s_axis_tdata[4:3]);
    assign store_wr.data  = s_axis_tdata[12:5];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lights_byte <= '0;
            r_dwell_ticks <= DWELL_RESET;
        end else if (i_cfg_we) begin
            unique case (int'(i_cfg_addr))
                CFG_LIGHTS: r_lights_byte <= i_cfg_wdata[7:0];
                CFG_DWELL:  r_dwell_ticks <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    rlms_frame_store #(
        .ROWS (ROWS)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (store_wr),
        .i_rd_row (scan_row),
        .o_colors (colors)
    );

    rlms_scan_core #(
        .ROWS (ROWS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_cmd    (cmd),
        .i_colors (colors),
        .i_lights (r_lights_byte),
        .i_dwell  (r_dwell_ticks),
        .o_row    (scan_row),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_out_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out.row_drive, r_out.serial_bit};
    assign m_axis_tuser  = r_out.shift_strobe;
    assign m_axis_tlast  = r_out.frame_end;

endmodule

`default_nettype wire

// ===== dv/row_scan_checker.sv =====
// ----------------------------------------------------------------------------
// row_scan_checker: scoreboard for the LED matrix row scanner
// Watches the item stream, the result stream and the register port. Every
// accepted item is run through a cycle-free model of the scan, and every
// accepted result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module row_scan_checker
    import rlms_pkg::*;
#(
    parameter int ROWS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [15:0] i_s_tdata,  // row_sel[2:0], plane[4:3], data[12:5]
    input  wire logic [0:0]  i_s_tuser,  // command[0]
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [15:0] i_m_tdata,  // serial_bit[0], row_drive[8:1]
    input  wire logic [0:0]  i_m_tuser,  // shift_strobe[0]
    input  wire logic        i_m_tlast,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_addr,
    input  wire logic [15:0] i_cfg_wdata,
    output int               o_fail_count,
    output int               o_pending
);

    logic [7:0]  lights_byte;
    logic [15:0] dwell_ticks;
    logic [7:0]  frame_store [3][ROWS];
    int unsigned scan_row;
    logic [4:0]  shift_pos;
    logic        dwelling;
    logic [15:0] dwell_count;

    t_result     scan_results_q [$];
    int          mismatches = 0;

    // Advances the scan model by one item and returns the result it causes.
    function automatic t_result scan_step(input t_cmd cmd, input logic [2:0] row_sel,
                                          input logic [1:0] plane, input logic [7:0] data);
        t_result     res;
        logic [31:0] word;
        logic [15:0] limit;
        logic [16:0] next_count;
        res = '0;
        res.row_drive = 8'hFF;
        if (dwelling && scan_row < 8) res.row_drive[scan_row] = 1'b0;
        if (cmd == CMD_WRITE) begin
            if (plane != PLANE_NONE && row_sel < ROWS) frame_store[plane][row_sel] = data;
        end else if (!dwelling) begin
            word = {lights_byte, frame_store[PLANE_RED][scan_row],
                    frame_store[PLANE_GREEN][scan_row], frame_store[PLANE_BLUE][scan_row]};
            res.serial_bit   = word[31 - shift_pos];
            res.shift_strobe = 1'b1;
            if (shift_pos == 5'd31) begin
                shift_pos   = '0;
                dwelling    = 1'b1;
                dwell_count = '0;
            end else begin
                shift_pos = shift_pos + 5'd1;
            end
        end else begin
            // A zero dwell behaves as one tick.
            limit      = (dwell_ticks == '0) ? 16'd1 : dwell_ticks;
            next_count = {1'b0, dwell_count} + 17'd1;
            if (next_count >= {1'b0, limit}) begin
                if (scan_row >= ROWS - 1) begin
                    res.frame_end = 1'b1;
                    scan_row      = 0;
                end else begin
                    scan_row = scan_row + 1;
                end
                dwelling    = 1'b0;
                dwell_count = '0;
                shift_pos   = '0;
            end else begin
                dwell_count = next_count[15:0];
            end
        end
        return res;
    endfunction

    function automatic void check_field(input string name, input int unsigned exp_val,
                                        input int unsigned act_val);
        if (exp_val != act_val) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result exp_res;
        if (!i_rst_n) begin
            lights_byte = '0;
            dwell_ticks = DWELL_RESET;
            for (int p = 0; p < 3; p++) begin
                for (int r = 0; r < ROWS; r++) frame_store[p][r] = '0;
            end
            scan_row    = 0;
            shift_pos   = '0;
            dwelling    = 1'b0;
            dwell_count = '0;
            scan_results_q.delete();
        end else begin
            // A result taken at this edge always belongs to an item accepted at an earlier edge.
            if (i_m_tvalid && i_m_tready) begin
                if (scan_results_q.size() == 0) begin
                    $error("result transfer arrived with no result expected");
                    mismatches++;
                end else begin
                    exp_res = scan_results_q.pop_front();
                    check_field("serial_bit", exp_res.serial_bit, i_m_tdata[0]);
                    check_field("shift_strobe", exp_res.shift_strobe, i_m_tuser[0]);
                    check_field("row_drive", exp_res.row_drive, i_m_tdata[8:1]);
                    check_field("frame_end", exp_res.frame_end, i_m_tlast);
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_LIGHTS) lights_byte = i_cfg_wdata[7:0];
                else if (i_cfg_addr == CFG_DWELL) dwell_ticks = i_cfg_wdata;
            end
            if (i_s_tvalid && i_s_tready) begin
                scan_results_q.push_back(scan_step(t_cmd'(i_s_tuser[0]), i_s_tdata[2:0],
                                                   i_s_tdata[4:3], i_s_tdata[12:5]));
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= scan_results_q.size();
    end

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the LED matrix row scanner
// Loads the frame store, ticks the scan through several register settings
// with random gaps on both streams and one long output stall, and lets the
// checker compare every result transfer against its own scan model.
// ----------------------------------------------------------------------------
module testbench;
    import rlms_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_PHASES  = 12;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;
    logic [0:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_we        = 1'b0;
    logic [0:0]  cfg_addr      = '0;
    logic [15:0] cfg_wdata     = '0;

    int   fail_count;
    int   pending;
    logic idle_on     = 1'b1;
    int   hold_asked  = 0;
    int   hold_served = 0;
    int   quiet_cycles = 0;

    rgb_led_matrix_row_scanner #(.ROWS(8)) i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (cfg_we),
        .i_cfg_addr    (cfg_addr),
        .i_cfg_wdata   (cfg_wdata)
    );

    row_scan_checker #(.ROWS(8)) i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .i_m_tlast    (m_axis_tlast),
        .i_cfg_we     (cfg_we),
        .i_cfg_addr   (cfg_addr),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    // tvalid is only lowered when a gap follows, so it never toggles in one step.
    task automatic send_item(input t_cmd cmd, input logic [2:0] row_sel,
                             input logic [1:0] plane, input logic [7:0] data);
        int gap;
        gap = idle_on ? $urandom_range(0, 16) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {3'b000, data, plane, row_sel};
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
    endtask

    // Stops the input stream and lets every expected result arrive.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Result side: a random stall before each result, or one long hold-off.
    initial begin : result_sink
        int stall;
        @(negedge clk);
        forever begin
            if (hold_asked != hold_served) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_served = hold_served + 1;
            end else begin
                stall = idle_on ? $urandom_range(0, 16) : 0;
                if (stall != 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(negedge clk);
                end
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            @(negedge clk);
        end
    end

    initial begin : stimulus
        int          n_items;
        logic [7:0]  lights;
        logic [15:0] dwell;
        t_cmd        cmd;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Store extremes at the reset settings, writes to the unused plane,
        // and a write into the row that is being shifted out.
        send_item(CMD_WRITE, 3'd0, PLANE_RED,   8'hFF);
        send_item(CMD_WRITE, 3'd0, PLANE_GREEN, 8'h00);
        send_item(CMD_WRITE, 3'd0, PLANE_BLUE,  8'h81);
        send_item(CMD_WRITE, 3'd7, PLANE_RED,   8'h5A);
        send_item(CMD_WRITE, 3'd7, PLANE_GREEN, 8'hA5);
        send_item(CMD_WRITE, 3'd7, PLANE_BLUE,  8'hFF);
        send_item(CMD_WRITE, 3'd3, PLANE_NONE,  8'hFF);
        send_item(CMD_WRITE, 3'd0, PLANE_NONE,  8'h00);
        repeat (10) send_item(CMD_TICK, 3'd7, PLANE_NONE, 8'hFF);
        send_item(CMD_WRITE, 3'd0, PLANE_RED, 8'h3C);
        repeat (6) send_item(CMD_TICK, 3'd0, PLANE_RED, 8'h00);
        drain();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            lights  = 8'($urandom_range(0, 255));
            dwell   = 16'($urandom_range(1, 12));
            n_items = 100;
            case (phase)
                0: begin lights = 8'hFF; dwell = 16'd1; end
                1: dwell = 16'd0;
                2: begin lights = 8'h00; dwell = 16'hFFFF; n_items = 60; end
                // Short dwell right after the longest one: the count already
                // reached may pass the new limit.
                3: dwell = 16'd3;
                default: if ($urandom_range(0, 3) == 0) dwell = 16'd1;
            endcase
            cfg_we    <= 1'b1;
            cfg_addr  <= 1'(CFG_LIGHTS);
            cfg_wdata <= {8'h00, lights};
            @(negedge clk);
            cfg_addr  <= 1'(CFG_DWELL);
            cfg_wdata <= dwell;
            @(negedge clk);
            cfg_we    <= 1'b0;
            idle_on = ($urandom_range(0, 3) != 0);
            if (phase == 4) begin
                // Sender keeps offering while the result side holds off.
                idle_on    = 1'b0;
                hold_asked = hold_asked + 1;
            end
            repeat (n_items) begin
                cmd = ($urandom_range(0, 5) == 0) ? CMD_WRITE : CMD_TICK;
                send_item(cmd, 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                          8'($urandom_range(0, 255)));
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
